// File: rtl/scd_pkg.sv
// Shared types and constants for the scene change detector.
// No dependencies; every other file of the block imports this package.
package scd_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned FRAME_W    = 23;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned DIVIDEND_W = SUM_W + FRAC_W;
  localparam int unsigned SCORE_W    = 18;
  localparam int unsigned CMP_W      = 28;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = FRAME_W'(307200);
  localparam logic [SCORE_W-1:0] SCORE_SAT        = '1;

  localparam logic [CMP_W-1:0] SCORE_FLOOR = CMP_W'(5 * 256);
  localparam logic [CMP_W-1:0] SCORE_HIGH  = CMP_W'(30 * 256);
  localparam logic [CMP_W-1:0] SCORE_TOP   = CMP_W'(50 * 256);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_SCAN,
    ST_DECIDE
  } scd_state_e;

  typedef struct packed {
    logic                done;
    logic [SCORE_W-1:0]  score;
  } scd_div_res_t;

  typedef struct packed {
    logic scan_start;
    logic commit;
  } scd_hist_ctl_t;

  typedef struct packed {
    logic scan_done;
    logic cut;
  } scd_verdict_t;

endpackage

// File: rtl/scd_divider.sv
// Restoring divider, one quotient bit per cycle, with saturation to the score width.
// Depends on scd_pkg.
module scd_divider import scd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [FRAME_W-1:0]    divisor_i,
  output scd_div_res_t          res_o
);

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [FRAME_W-1:0]    rem_q, rem_d;
  logic [FRAME_W-1:0]    div_q, div_d;
  logic [FRAME_W:0]      trial;
  logic [FRAME_W:0]      diff;
  logic                  fits;

  assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVIDEND_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[DIVIDEND_W-2:0], fits};
        rem_d = fits ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.done  = busy_q && (cnt_q == '0);
  assign res_o.score = (|dvd_q[DIVIDEND_W-1:SCORE_W]) ? SCORE_SAT : dvd_q[SCORE_W-1:0];

endmodule

// File: rtl/scd_history.sv
// Score history with a sequential max/min scan and the cut decision.
// Depends on scd_pkg.
module scd_history import scd_pkg::*; #(
  parameter int unsigned HISTORY_LEN = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scd_hist_ctl_t      ctl_i,
  input  logic [SCORE_W-1:0] score_i,
  output scd_verdict_t       verdict_o
);

  localparam int unsigned DEPTH  = HISTORY_LEN - 1;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SEEN_W = $clog2(HISTORY_LEN + 1);

  logic [SCORE_W-1:0] hist_q [DEPTH];
  logic [SEEN_W-1:0]  seen_q;
  logic [SEEN_W-1:0]  seen_inc;
  logic               scan_q;
  logic [CNT_W-1:0]   idx_q;
  logic [SCORE_W-1:0] max_q, min_q;
  logic [SCORE_W-1:0] probe;
  logic [CMP_W-1:0]   s_w, mx_w, mn_w, p_w, t5;
  logic               cut;

  assign probe = hist_q[idx_q[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
      idx_q  <= '0;
    end else if (ctl_i.scan_start) begin
      scan_q <= 1'b1;
      idx_q  <= CNT_W'(1);
    end else if (scan_q) begin
      if (idx_q == CNT_W'(DEPTH)) begin
        scan_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_start) begin
      max_q <= hist_q[0];
      min_q <= hist_q[0];
    end else if (scan_q && (idx_q != CNT_W'(DEPTH))) begin
      if (probe > max_q) max_q <= probe;
      if (probe < min_q) min_q <= probe;
    end
  end

  assign seen_inc = (seen_q < SEEN_W'(HISTORY_LEN)) ? seen_q + 1'b1 : seen_q;

  assign s_w  = CMP_W'(score_i);
  assign mx_w = CMP_W'(max_q);
  assign mn_w = CMP_W'(min_q);
  assign p_w  = CMP_W'(hist_q[DEPTH-1]);
  assign t5   = (mx_w << 3) + mx_w - (mn_w << 2);

  always_comb begin
    cut = 1'b0;
    if ((seen_inc >= SEEN_W'(HISTORY_LEN)) && (s_w >= SCORE_FLOOR)
        && (s_w * CMP_W'(5) >= t5)) begin
      if ((s_w > SCORE_HIGH) && (s_w * CMP_W'(10) > p_w * CMP_W'(14))) begin
        cut = 1'b1;
      end else if (s_w * CMP_W'(50) > t5 * CMP_W'(23)) begin
        cut = 1'b1;
      end else if (s_w > SCORE_TOP) begin
        cut = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < DEPTH; i++) hist_q[i] <= '0;
    end else if (ctl_i.commit) begin
      if (cut) begin
        seen_q <= '0;
        for (int i = 0; i < DEPTH; i++) hist_q[i] <= '0;
      end else begin
        seen_q <= seen_inc;
        for (int i = 0; i < DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
        hist_q[DEPTH-1] <= score_i;
      end
    end
  end

  assign verdict_o.scan_done = scan_q && (idx_q == CNT_W'(DEPTH));
  assign verdict_o.cut       = cut;

endmodule

// File: rtl/scene_change_detector.sv
// Top level of the scene change detector: sample accumulator, sequencer and result register.
// Depends on scd_pkg, scd_divider and scd_history.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------------
//   input    | in_valid_i / in_stall_o | current_sample_i, previous_sample_i, end_of_frame_i
//   output   | out_valid_o/out_stall_i | scene_cut_o, frame_score_o
//   config   | cfg_we_i                | cfg_wdata_i (frame_pixels)
//
// Sample beats without end of frame are accepted back to back, with no stall.
// An end-of-frame beat stalls the input while the bit-serial divider runs, and then through
// the history scan and the decision.
// The decision also waits while the previous result is still held on the output.
// Reset clears the sum, history, count and valid flags and loads frame_pixels with 307200.
module scene_change_detector import scd_pkg::*; #(
  parameter int unsigned HISTORY_LEN = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FRAME_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] current_sample_i,
  input  logic [SAMPLE_W-1:0] previous_sample_i,
  input  logic                end_of_frame_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                scene_cut_o,
  output logic [SCORE_W-1:0]  frame_score_o
);

  scd_state_e         state_q, state_d;
  logic [FRAME_W-1:0] pixels_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SAMPLE_W-1:0] abs_diff;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_next;
  logic               in_beat;
  logic               slot_free;
  logic               div_start;
  scd_div_res_t       div_res;
  scd_hist_ctl_t      hist_ctl;
  scd_verdict_t       verdict;
  logic               out_valid_q, out_valid_d;
  logic               cut_q;
  logic [SCORE_W-1:0] score_q;

  assign in_beat   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign abs_diff  = (current_sample_i > previous_sample_i) ?
                     current_sample_i - previous_sample_i :
                     previous_sample_i - current_sample_i;
  assign sum_wide  = {1'b0, sum_q} + (SUM_W + 1)'(abs_diff);
  assign sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM:  if (in_beat && end_of_frame_i) state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_res.done) state_d = ST_SCAN;
      ST_SCAN:   if (verdict.scan_done) state_d = ST_DECIDE;
      ST_DECIDE: if (slot_free) state_d = ST_ACCUM;
      default:   state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    in_stall_o          = 1'b1;
    div_start           = 1'b0;
    hist_ctl.scan_start = 1'b0;
    hist_ctl.commit     = 1'b0;
    sum_d               = sum_q;
    out_valid_d         = out_valid_q && out_stall_i;
    case (state_q)
      ST_ACCUM: begin
        in_stall_o = 1'b0;
        if (in_beat) begin
          sum_d     = end_of_frame_i ? '0 : sum_next;
          div_start = end_of_frame_i;
        end
      end
      ST_DIVIDE: hist_ctl.scan_start = div_res.done;
      ST_SCAN: ;
      ST_DECIDE: begin
        if (slot_free) begin
          hist_ctl.commit = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      pixels_q    <= FRAME_PIXELS_RST;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) pixels_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_ctl.commit) begin
      cut_q   <= verdict.cut;
      score_q <= div_res.score;
    end
  end

  scd_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_next, FRAC_W'(0)}),
    .divisor_i  ((pixels_q == '0) ? FRAME_W'(1) : pixels_q),
    .res_o      (div_res)
  );

  scd_history #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hist_ctl),
    .score_i   (div_res.score),
    .verdict_o (verdict)
  );

  assign out_valid_o   = out_valid_q;
  assign scene_cut_o   = cut_q;
  assign frame_score_o = score_q;

endmodule

// File: tb/tb_scene_change_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for scene_change_detector: sends sample beats with random idling,
// predicts each frame's score and cut verdict, and checks every result beat in order.
// Depends on scd_pkg and the scene_change_detector RTL.
module tb_scene_change_detector;
  import scd_pkg::*;

  localparam int unsigned HLEN         = 5;
  localparam int unsigned DEPTH        = HLEN - 1;
  localparam int unsigned DRAIN_CYCLES = HLEN + 48;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam longint unsigned Q8        = 256;
  localparam longint unsigned SUM_CAP   = 64'hFFFF_FFFF;
  localparam longint unsigned SCORE_CAP = 262143;

  typedef struct packed {
    logic               cut;
    logic [SCORE_W-1:0] score;
  } frame_verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FRAME_W-1:0]  cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] current_sample_i;
  logic [SAMPLE_W-1:0] previous_sample_i;
  logic                end_of_frame_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                scene_cut_o;
  logic [SCORE_W-1:0]  frame_score_o;

  longint unsigned     acc_sum = 0;
  logic [SCORE_W-1:0]  score_hist [DEPTH] = '{default: '0};
  int unsigned         seen_cnt = 0;
  logic [FRAME_W-1:0]  pixel_div = 23'd307200;
  frame_verdict_t      verdict_q [$];

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cuts_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned fail_count = 0;

  scene_change_detector #(
    .HISTORY_LEN(HLEN)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .current_sample_i (current_sample_i),
    .previous_sample_i(previous_sample_i),
    .end_of_frame_i   (end_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scene_cut_o      (scene_cut_o),
    .frame_score_o    (frame_score_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic predict_beat(input logic [SAMPLE_W-1:0] cur, input logic [SAMPLE_W-1:0] prev,
                              input logic eof);
    longint unsigned d, divisor, s, hi, lo, newest, t5;
    logic cut;
    frame_verdict_t v;
    d = (cur > prev) ? cur - prev : prev - cur;
    acc_sum = (acc_sum > SUM_CAP - d) ? SUM_CAP : acc_sum + d;
    if (!eof) return;
    divisor = (pixel_div == '0) ? 1 : pixel_div;
    s = (acc_sum << 8) / divisor;
    if (s > SCORE_CAP) s = SCORE_CAP;
    acc_sum = 0;
    if (seen_cnt < HLEN) seen_cnt++;
    hi = score_hist[0];
    lo = score_hist[0];
    newest = score_hist[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      if (score_hist[i] > hi) hi = score_hist[i];
      if (score_hist[i] < lo) lo = score_hist[i];
    end
    t5 = 9 * hi - 4 * lo;
    cut = (seen_cnt >= HLEN) && (s >= 5 * Q8) && (5 * s >= t5) &&
          ((s > 30 * Q8 && 10 * s > 14 * newest) || (50 * s > 23 * t5) || (s > 50 * Q8));
    if (cut) begin
      score_hist = '{default: '0};
      seen_cnt = 0;
    end else begin
      for (int i = 0; i < DEPTH - 1; i++) score_hist[i] = score_hist[i+1];
      score_hist[DEPTH-1] = s[SCORE_W-1:0];
    end
    v.cut = cut;
    v.score = s[SCORE_W-1:0];
    verdict_q = {verdict_q, v};
  endtask

  task automatic send_beat(input logic [SAMPLE_W-1:0] cur, input logic [SAMPLE_W-1:0] prev,
                           input logic eof);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    current_sample_i  <= cur;
    previous_sample_i <= prev;
    end_of_frame_i    <= eof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_beat(cur, prev, eof);
    beats_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned level, input bit noisy);
    int d, jit;
    logic [SAMPLE_W-1:0] lo_s, hi_s;
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy) begin
        hi_s = SAMPLE_W'($urandom);
        lo_s = SAMPLE_W'($urandom);
      end else begin
        jit = level / 8 + 1;
        d = int'(level) + int'($urandom_range(0, 2 * jit)) - jit;
        if (d < 0) d = 0;
        else if (d > 255) d = 255;
        lo_s = SAMPLE_W'($urandom_range(0, 255 - d));
        hi_s = SAMPLE_W'(int'(lo_s) + d);
        if ($urandom_range(0, 1)) {lo_s, hi_s} = {hi_s, lo_s};
      end
      send_beat(hi_s, lo_s, i == len - 1);
    end
  endtask

  task automatic park_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic set_frame_pixels(input logic [FRAME_W-1:0] pix);
    park_input();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pix;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    pixel_div = pix;
    cfg_writes++;
  endtask

  task automatic test_reset_divisor();
    send_beat(8'hFF, 8'h00, 1'b0);
    send_beat(8'h00, 8'hFF, 1'b0);
    send_beat(8'h80, 8'h80, 1'b1);
    send_beat(8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_divisor_extremes();
    set_frame_pixels('0);
    for (int i = 0; i < 5; i++) send_beat(8'hFF, 8'h00, i == 4);
    set_frame_pixels('1);
    send_beat(8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_decision_paths();
    int unsigned steps [18] = '{8, 8, 8, 8, 8, 40, 3, 3, 3, 3, 4, 6, 55, 55, 55, 55, 55, 60};
    set_frame_pixels(23'd1);
    foreach (steps[i]) send_beat(8'hFF, 8'(255 - steps[i]), 1'b1);
  endtask

  task automatic test_output_backpressure();
    set_frame_pixels(23'd2);
    hold_left = 400;
    for (int i = 0; i < 6; i++) send_frame(2, $urandom_range(20, 200), 1'b0);
  endtask

  task automatic run_scene_phase(input logic [FRAME_W-1:0] pix, input int unsigned target);
    int unsigned first_beat, len, level;
    bit noisy;
    set_frame_pixels(pix);
    first_beat = beats_sent;
    level = $urandom_range(0, 12);
    while (beats_sent - first_beat < target) begin
      if ($urandom_range(0, 5) == 0)
        level = $urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(0, 255);
      noisy = ($urandom_range(0, 9) == 0);
      if (pix >= 1 && pix <= 8)
        len = ($urandom_range(0, 3) != 0) ? pix : $urandom_range(1, 2 * pix);
      else
        len = $urandom_range(1, 8);
      send_frame(len, level, noisy);
    end
  endtask

  task automatic test_random_scenes();
    logic [FRAME_W-1:0] phase_pix [10] = '{23'd3, 23'd1, 23'h7FFFFF, 23'd5, 23'd0, 23'd2,
                                           23'd4194304, 23'd6, 23'd4, 23'd7};
    foreach (phase_pix[ph]) begin
      tx_idle_on = (ph < 8) && (ph != 3);
      rx_idle_on = tx_idle_on;
      run_scene_phase(phase_pix[ph], (phase_pix[ph] <= 8) ? 180 : 50);
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected result beat: cut %0b score %0d", scene_cut_o, frame_score_o);
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (scene_cut_o) cuts_seen++;
        if (scene_cut_o !== want.cut || frame_score_o !== want.score) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("result %0d mismatch: cut exp %0b got %0b, score exp %0d got %0d",
                     results_checked, want.cut, scene_cut_o, want.score, frame_score_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a beat", quiet_cycles);
      $display("tb_scene_change_detector: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    current_sample_i  <= '0;
    previous_sample_i <= '0;
    end_of_frame_i    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_divisor();
    test_divisor_extremes();
    test_decision_paths();
    test_output_backpressure();
    test_random_scenes();
    park_input();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d sample beats and %0d frame results (%0d cuts) over %0d divisor writes.",
             beats_sent, results_checked, cuts_seen, cfg_writes);
    if (fail_count == 0) begin
      $display("tb_scene_change_detector: clean");
    end else begin
      $display("%0d failing result beats", fail_count);
      $display("tb_scene_change_detector: errors");
    end
    $finish;
  end

endmodule
